// File: hw/rtl/qnco_pkg.sv
// quadrature oscillator bank: shared widths, reset values and quarter-wave table function
`timescale 1ns / 1ps
`default_nettype none

package qnco_pkg;

	localparam int CH_W     = 3;
	localparam int KNOB_W   = 17;
	localparam int CV_W     = 16;
	localparam int OUT_W    = 16;
	localparam int PERIOD_W = 32;
	localparam int ENTRY_W  = 15;
	// knob << 11 plus depth * cv, signed
	localparam int MOD_W    = 34;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd89478;
	localparam logic [63:0]         PI_Q40       = 64'd3454217652358;
	localparam logic [ENTRY_W-1:0]  ENTRY_MAX    = 15'd32767;

	// term / ((2k)(2k+1)) of the sine series
	function automatic logic [63:0] series_div(logic [63:0] t, int k);
		logic [63:0] q;
		q = t;
		case (k)
			1:       q = t / 64'd6;
			2:       q = t / 64'd20;
			3:       q = t / 64'd42;
			4:       q = t / 64'd72;
			5:       q = t / 64'd110;
			6:       q = t / 64'd156;
			7:       q = t / 64'd210;
			8:       q = t / 64'd272;
			9:       q = t / 64'd342;
			10:      q = t / 64'd420;
			default: q = t;
		endcase
		return q;
	endfunction

	// entry idx of a quarter-wave table of 2^addr_bits entries, q30 series
	function automatic logic [ENTRY_W-1:0] quarter_entry(int unsigned idx, int unsigned addr_bits);
		logic [63:0]        num;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic [63:0]        e;
		int unsigned        sh;
		num  = PI_Q40 * 64'(2 * idx + 1);
		sh   = addr_bits + 12;
		x    = (num + (64'd1 << (sh - 1))) >> sh;
		x2   = (x * x) >> 30;
		term = x;
		sum  = signed'(x);
		for (int k = 1; k <= 10; k++) begin
			term = (term * x2) >> 30;
			term = series_div(term, k);
			if ((k & 1) != 0) begin
				sum = sum - signed'(term);
			end else begin
				sum = sum + signed'(term);
			end
		end
		if (sum < 0) begin
			sum = '0;
		end
		e = (unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
		if (e > 64'(ENTRY_MAX)) begin
			e = 64'(ENTRY_MAX);
		end
		return e[ENTRY_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/qnco_in_if.sv
// request channel of the oscillator bank: one channel's sample tick
`timescale 1ns / 1ps
`default_nettype none

interface qnco_in_if;
	import qnco_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CH_W-1:0]          channel;
	logic [KNOB_W-1:0]        base_freq;
	logic [KNOB_W-1:0]        fm_depth;
	logic signed [CV_W-1:0]   fm_cv;
	logic [KNOB_W-1:0]        base_amp;
	logic [KNOB_W-1:0]        am_depth;
	logic signed [CV_W-1:0]   am_cv;

	modport source (
		output valid, channel, base_freq, fm_depth, fm_cv, base_amp, am_depth, am_cv,
		input  ready
	);
	modport sink (
		input  valid, channel, base_freq, fm_depth, fm_cv, base_amp, am_depth, am_cv,
		output ready
	);
endinterface

`default_nettype wire

// File: hw/rtl/qnco_out_if.sv
// result channel of the oscillator bank: sine and cosine of one tick
`timescale 1ns / 1ps
`default_nettype none

interface qnco_out_if;
	import qnco_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CH_W-1:0]          out_channel;
	logic signed [OUT_W-1:0]  sine_out;
	logic signed [OUT_W-1:0]  cosine_out;

	modport source (
		output valid, out_channel, sine_out, cosine_out,
		input  ready
	);
	modport sink (
		input  valid, out_channel, sine_out, cosine_out,
		output ready
	);
endinterface

`default_nettype wire

// File: hw/rtl/quadrature_nco_fm_am.sv
// Time-multiplexed quadrature oscillator bank with FM and AM.
//
// tick is the request channel: one sample tick of one channel with its
// frequency and amplitude knobs and modulation voltages. sample returns one
// result per request, in order: the channel, amplitude * sine and
// amplitude * cosine, saturated to 16 bits. cfg_we / cfg_wdata write the
// sample period at any edge with cfg_we high.
// Each request passes every stage and the output register. One request
// enters per cycle while tick.ready is high; the phase memory is read one
// stage ahead of the add, and the previous tick's result is forwarded
// when the channel repeats. Sine and cosine come from a two-port quarter-wave
// ROM with registered read. All stages advance together: while sample holds
// a result that is not taken, the pipeline freezes and tick.ready is low.
// Reset clears all phases to zero (per-channel valid bits), sets the sample
// period to its default and empties the pipeline. A channel outside the bank
// leaves the phases alone and returns zero outputs.
`timescale 1ns / 1ps
`default_nettype none

module quadrature_nco_fm_am #(
	parameter int CHANNELS        = 5,
	parameter int PHASE_BITS      = 32,
	parameter int TABLE_ADDR_BITS = 10
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [qnco_pkg::PERIOD_W-1:0]   cfg_wdata,
	qnco_in_if.sink                              tick,
	qnco_out_if.source                           sample
);
	import qnco_pkg::*;

	localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int TABLE_SIZE = 1 << TABLE_ADDR_BITS;
	localparam int PROD_W     = MOD_W + PERIOD_W + 1;
	localparam int SCALE_W    = OUT_W + MOD_W;
	localparam int SHIFT_W    = SCALE_W - 31;

	// sample period register
	logic [PERIOD_W-1:0] period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			period_q <= cfg_wdata;
		end
	end

	// quarter-wave table, built at elaboration
	logic [ENTRY_W-1:0] rom_w [TABLE_SIZE];

	for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_rom
		localparam logic [ENTRY_W-1:0] ENTRY = quarter_entry(g, TABLE_ADDR_BITS);
		assign rom_w[g] = ENTRY;
	end

	logic advance;
	logic out_valid_q;

	assign advance    = !out_valid_q || sample.ready;
	assign tick.ready = advance;

	// stage 1: captured request
	logic                   v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [CH_W-1:0]        ch_s1, ch_s2, ch_s3, ch_s4, ch_s5, ch_s6;
	logic                   inr_s1, inr_s2, inr_s3, inr_s4, inr_s5, inr_s6;
	logic [CH_IDX_W-1:0]    idx_s1, idx_s2, idx_s3, idx_s4;
	logic [KNOB_W-1:0]      bfreq_s1, fdep_s1, bamp_s1, adep_s1;
	logic signed [CV_W-1:0] fcv_s1, acv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (advance) begin
			v_s1 <= tick.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ch_s1    <= tick.channel;
			inr_s1   <= (32'(tick.channel) < CHANNELS);
			idx_s1   <= CH_IDX_W'(tick.channel);
			bfreq_s1 <= tick.base_freq;
			fdep_s1  <= tick.fm_depth;
			fcv_s1   <= tick.fm_cv;
			bamp_s1  <= tick.base_amp;
			adep_s1  <= tick.am_depth;
			acv_s1   <= tick.am_cv;
		end
	end

	// stage 2: frequency and amplitude in signed q17.16 (34 bits with sign)
	logic signed [MOD_W-1:0] freq_w, amp_w;
	logic signed [MOD_W-1:0] freq_s2, amp_s2;

	always_comb begin
		freq_w = $signed(MOD_W'({bfreq_s1, 11'd0}))
			+ (MOD_W'($signed({1'b0, fdep_s1})) * MOD_W'(fcv_s1));
		amp_w  = $signed(MOD_W'({bamp_s1, 11'd0}))
			+ (MOD_W'($signed({1'b0, adep_s1})) * MOD_W'(acv_s1));
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ch_s2   <= ch_s1;
			inr_s2  <= inr_s1;
			idx_s2  <= idx_s1;
			freq_s2 <= freq_w;
			amp_s2  <= amp_w;
		end
	end

	// stage 3: phase increment, phase memory read issued from stage 2
	logic signed [PROD_W-1:0]     inc_prod_w;
	logic [PHASE_BITS-1:0]        inc_s3;
	logic signed [MOD_W-1:0]      amp_s3, amp_s4, amp_s5;
	logic [PHASE_BITS-1:0]        phase_mem [CHANNELS];
	logic [CHANNELS-1:0]          pvalid_q;
	logic [PHASE_BITS-1:0]        rd_s3;
	logic                         rd_ok_s3;
	logic [CH_IDX_W-1:0]          rd_idx;

	assign inc_prod_w = freq_s2 * $signed({1'b0, period_q});
	assign rd_idx     = inr_s2 ? idx_s2 : '0;

	always_ff @(posedge clk) begin
		if (advance) begin
			ch_s3  <= ch_s2;
			inr_s3 <= inr_s2;
			idx_s3 <= idx_s2;
			amp_s3 <= amp_s2;
			inc_s3 <= inc_prod_w[47 -: PHASE_BITS];
			rd_s3  <= phase_mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ok_s3 <= 1'b0;
		end else if (advance) begin
			rd_ok_s3 <= pvalid_q[rd_idx];
		end
	end

	// stage 4: phase add and write-back
	logic [PHASE_BITS-1:0] old_ph;
	logic [PHASE_BITS-1:0] new_ph;
	logic [PHASE_BITS-1:0] ph_s4;
	logic                  wr_en;

	always_comb begin
		// previous tick of the same channel wrote after this read was issued
		if (v_s4 && inr_s4 && (idx_s4 == idx_s3)) begin
			old_ph = ph_s4;
		end else if (rd_ok_s3) begin
			old_ph = rd_s3;
		end else begin
			old_ph = '0;
		end
		new_ph = old_ph + inc_s3;
	end

	assign wr_en = advance && v_s3 && inr_s3;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			phase_mem[idx_s3] <= new_ph;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvalid_q <= '0;
		end else if (wr_en) begin
			pvalid_q[idx_s3] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ch_s4  <= ch_s3;
			inr_s4 <= inr_s3;
			idx_s4 <= idx_s3;
			amp_s4 <= amp_s3;
			ph_s4  <= new_ph;
		end
	end

	// stage 5: rom read for sine and cosine
	logic [1:0]                 sq, cq;
	logic [TABLE_ADDR_BITS-1:0] ph_addr, s_addr, c_addr;
	logic [ENTRY_W-1:0]         sent_s5, cent_s5;
	logic                       sneg_s5, cneg_s5;

	always_comb begin
		sq      = ph_s4[PHASE_BITS-1 -: 2];
		cq      = sq + 2'd1;
		ph_addr = ph_s4[PHASE_BITS-3 -: TABLE_ADDR_BITS];
		s_addr  = sq[0] ? ~ph_addr : ph_addr;
		c_addr  = cq[0] ? ~ph_addr : ph_addr;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ch_s5   <= ch_s4;
			inr_s5  <= inr_s4;
			amp_s5  <= amp_s4;
			sent_s5 <= rom_w[s_addr];
			cent_s5 <= rom_w[c_addr];
			sneg_s5 <= sq[1];
			cneg_s5 <= cq[1];
		end
	end

	// stage 6: scale by amplitude
	logic signed [OUT_W-1:0]   sval, cval;
	logic signed [SCALE_W-1:0] sprod_s6, cprod_s6;

	always_comb begin
		sval = sneg_s5 ? -$signed({1'b0, sent_s5}) : $signed({1'b0, sent_s5});
		cval = cneg_s5 ? -$signed({1'b0, cent_s5}) : $signed({1'b0, cent_s5});
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ch_s6    <= ch_s5;
			inr_s6   <= inr_s5;
			sprod_s6 <= sval * amp_s5;
			cprod_s6 <= cval * amp_s5;
		end
	end

	// output register: round, shift, saturate
	function automatic logic signed [OUT_W-1:0] round_sat(logic signed [SCALE_W-1:0] p);
		logic signed [SCALE_W-1:0] r;
		logic signed [SHIFT_W-1:0] s;
		logic signed [OUT_W-1:0]   o;
		r = p + $signed(SCALE_W'(1) << 30);
		s = SHIFT_W'(r >>> 31);
		if (s > $signed(SHIFT_W'(32767))) begin
			o = 16'sh7fff;
		end else if (s < -$signed(SHIFT_W'(32768))) begin
			o = 16'sh8000;
		end else begin
			o = OUT_W'(s);
		end
		return o;
	endfunction

	logic [CH_W-1:0]         out_ch_q;
	logic signed [OUT_W-1:0] sine_q, cosine_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_ch_q <= ch_s6;
			sine_q   <= inr_s6 ? round_sat(sprod_s6) : '0;
			cosine_q <= inr_s6 ? round_sat(cprod_s6) : '0;
		end
	end

	assign sample.valid       = out_valid_q;
	assign sample.out_channel = out_ch_q;
	assign sample.sine_out    = sine_q;
	assign sample.cosine_out  = cosine_q;

	// write-back lands in the entry the next stage forwards from
	a_wb_data: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && v_s3 && inr_s3) |=> (phase_mem[idx_s4] == ph_s4))
		else $error("phase write-back does not match forwarded phase");

	a_wb_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && v_s3 && inr_s3) |=> pvalid_q[idx_s4])
		else $error("phase entry not marked valid after write-back");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!tick.ready |-> sample.valid)
		else $error("request stalled with no result waiting");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && v_s6 && !inr_s6) |=> (sample.sine_out == '0 && sample.cosine_out == '0))
		else $error("channel outside the bank gave nonzero output");

endmodule

`default_nettype wire
